>>> design/vlt_pkg.sv
// ----------------------------------------------------------------------------
// vlt_pkg
// Types and codes shared by the vote lockout tower modules.
// ----------------------------------------------------------------------------
package vlt_pkg;

  localparam int SLOT_W     = 64;
  localparam int COUNT_W    = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int ENTRY_W    = SLOT_W + COUNT_W;

  localparam logic [2:0] OP_CHECK    = 3'd0;
  localparam logic [2:0] OP_RECORD   = 3'd1;
  localparam logic [2:0] OP_SETCOUNT = 3'd2;
  localparam logic [2:0] OP_RESET    = 3'd3;
  localparam logic [2:0] OP_LOOKUP   = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BELOW_ROOT = 3'd1;
  localparam logic [2:0] ST_NOT_AFTER  = 3'd2;
  localparam logic [2:0] ST_LOCKED     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOCKOUT    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_THRESHOLD = 8'd1;

  localparam logic [63:0] MAX_LOCKOUT_RESET    = 64'h0000_0000_8000_0000;
  localparam logic [7:0]  BASE_THRESHOLD_RESET = 8'd8;

  typedef struct packed {
    logic [2:0]         op;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count_value;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [63:0]       lockout;
    logic [8:0]        threshold;
    logic [SLOT_W-1:0] root_now;
    logic [SLOT_W-1:0] last_vote_now;
    logic [5:0]        height;
  } out_t;

  typedef struct packed {
    logic [63:0] max_lockout;
    logic [7:0]  base_threshold;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

endpackage

>>> design/vote_lockout_tower_core.sv
// ----------------------------------------------------------------------------
// vote_lockout_tower_core
// Bounded vote lockout tower with root and last vote tracking.
// ----------------------------------------------------------------------------
// usage
//   in channel: one transfer per operation (check, record, set count, reset
//   root, lookup); each produces exactly one transfer on the out channel.
//   cfg channel: max_lockout (index 0) and base_threshold (index 1), always
//   ready; write only while no operation is outstanding.
//   the walk reads entries one per cycle from the entry memory, so the time
//   from in transfer to out transfer grows with the tower height; reset root
//   and unused codes skip the walk. one operation is in flight at a time;
//   in_ready returns the cycle after the result moves into the output
//   register.
//   the output register lets the next operation be taken while a result waits.
//   reset: tower empty, root and last vote zero, registers at their defaults;
//   the entry memory is not cleared and needs no clearing pass.
//   a stalled out channel holds its result; the engine then waits with its
//   next result until the output register frees.
// ----------------------------------------------------------------------------
module vote_lockout_tower_core #(
  parameter int TOWER_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  vlt_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vlt_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vlt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                       cfg_data
);

  vlt_pkg::cfg_t cfg;
  vlt_pkg::out_t res_data;
  logic          res_valid;
  logic          res_ready;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_lockout    <= vlt_pkg::MAX_LOCKOUT_RESET;
      cfg.base_threshold <= vlt_pkg::BASE_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vlt_pkg::CFG_MAX_LOCKOUT:    cfg.max_lockout    <= cfg_data;
        vlt_pkg::CFG_BASE_THRESHOLD: cfg.base_threshold <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res_data;
    end
  end

  vlt_engine #(
    .TOWER_DEPTH (TOWER_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

>>> design/vlt_ram.sv
// ----------------------------------------------------------------------------
// vlt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vlt_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/vlt_engine.sv
// ----------------------------------------------------------------------------
// vlt_engine
// Tower state, entry memory walk and read-modify-write sequencer.
// ----------------------------------------------------------------------------
module vlt_engine #(
  parameter int TOWER_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  vlt_pkg::in_t  in_data,
  input  vlt_pkg::cfg_t cfg,
  output logic          res_valid,
  input  logic          res_ready,
  output vlt_pkg::out_t res_data
);

  localparam int IDX_W = (TOWER_DEPTH > 1) ? $clog2(TOWER_DEPTH) : 1;
  localparam int CNT_W = $clog2(TOWER_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOWER_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TOWER_DEPTH);
  localparam logic [IDX_W:0]   DEPTH_W  = (IDX_W + 1)'(TOWER_DEPTH);

  function automatic logic [63:0] lockout_of(input logic [7:0] c, input logic [63:0] cap);
    logic [63:0] p;
    p = 64'd1 << c[5:0];
    if (c >= 8'd64) begin
      return cap;
    end
    return (p < cap) ? p : cap;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
    return (a == LAST_IDX) ? '0 : a + IDX_W'(1);
  endfunction

  vlt_pkg::state_t state, state_next;
  vlt_pkg::in_t    req;

  logic [63:0]      root, root_next;
  logic [63:0]      last_vote, last_vote_next;
  logic [IDX_W-1:0] oldest, oldest_next;
  logic [CNT_W-1:0] total, total_next;

  logic [CNT_W-1:0] issue_cnt;
  logic [IDX_W-1:0] rd_addr;
  logic             issue;

  logic             rd_v, rd_first;
  logic [IDX_W-1:0] rd_addr_q;

  logic             s1_v, s1_first;
  logic [63:0]      s1_slot, s1_lk;
  logic [7:0]       s1_cnt;
  logic [IDX_W-1:0] s1_addr;

  logic             locked, found;
  logic [IDX_W-1:0] f_addr;
  logic [7:0]       f_cnt;
  logic [63:0]      f_lk;
  logic [63:0]      oldest_slot;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [vlt_pkg::ENTRY_W-1:0] ram_wdata;
  logic [vlt_pkg::ENTRY_W-1:0] ram_rdata;

  logic [IDX_W:0]   wpos_sum;
  logic [IDX_W-1:0] wpos;
  logic [2:0]       vote_st;
  logic             finish_fire;

  vlt_ram #(
    .WIDTH (vlt_pkg::ENTRY_W),
    .DEPTH (TOWER_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign in_ready    = (state == vlt_pkg::S_IDLE);
  assign issue       = (state == vlt_pkg::S_WALK) && (issue_cnt != total);
  assign finish_fire = (state == vlt_pkg::S_FINISH) && res_ready;

  // tail position for a record into a tower that is not full
  assign wpos_sum = {1'b0, oldest} + (IDX_W + 1)'(total);
  assign wpos     = (wpos_sum >= DEPTH_W) ? IDX_W'(wpos_sum - DEPTH_W) : wpos_sum[IDX_W-1:0];

  always_comb begin
    if (req.slot < root) begin
      vote_st = vlt_pkg::ST_BELOW_ROOT;
    end else if (req.slot <= last_vote) begin
      vote_st = vlt_pkg::ST_NOT_AFTER;
    end else if (locked) begin
      vote_st = vlt_pkg::ST_LOCKED;
    end else begin
      vote_st = vlt_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vlt_pkg::S_IDLE;
      root      <= '0;
      last_vote <= '0;
      oldest    <= '0;
      total     <= '0;
      rd_v      <= 1'b0;
      s1_v      <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= issue;
      s1_v  <= rd_v;
      if (finish_fire) begin
        root      <= root_next;
        last_vote <= last_vote_next;
        oldest    <= oldest_next;
        total     <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req       <= in_data;
      issue_cnt <= '0;
      rd_addr   <= oldest;
      locked    <= 1'b0;
      found     <= 1'b0;
    end
    if (issue) begin
      issue_cnt <= issue_cnt + CNT_W'(1);
      rd_addr   <= wrap_inc(rd_addr);
    end
    rd_first  <= (issue_cnt == '0);
    rd_addr_q <= rd_addr;

    s1_first <= rd_first;
    s1_slot  <= ram_rdata[vlt_pkg::ENTRY_W-1:vlt_pkg::COUNT_W];
    s1_cnt   <= ram_rdata[vlt_pkg::COUNT_W-1:0];
    s1_lk    <= lockout_of(ram_rdata[vlt_pkg::COUNT_W-1:0], cfg.max_lockout);
    s1_addr  <= rd_addr_q;

    if (s1_v) begin
      // window is (entry, entry + lockout], end saturating
      if ((s1_slot < req.slot) && ((req.slot - s1_slot) <= s1_lk)) begin
        locked <= 1'b1;
      end
      if ((s1_slot == req.slot) && !found) begin
        found  <= 1'b1;
        f_addr <= s1_addr;
        f_cnt  <= s1_cnt;
        f_lk   <= s1_lk;
      end
      if (s1_first) begin
        oldest_slot <= s1_slot;
      end
    end
  end

  always_comb begin
    state_next     = state;
    root_next      = root;
    last_vote_next = last_vote;
    oldest_next    = oldest;
    total_next     = total;
    ram_we         = 1'b0;
    ram_waddr      = wpos;
    ram_wdata      = {req.slot, 8'd0};
    res_valid      = 1'b0;
    res_data       = '0;

    unique case (state)
      vlt_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.op inside {vlt_pkg::OP_CHECK, vlt_pkg::OP_RECORD,
                                 vlt_pkg::OP_SETCOUNT, vlt_pkg::OP_LOOKUP}) begin
            state_next = vlt_pkg::S_WALK;
          end else begin
            state_next = vlt_pkg::S_FINISH;
          end
        end
      end
      vlt_pkg::S_WALK: begin
        if (!issue && !rd_v && !s1_v) begin
          state_next = vlt_pkg::S_FINISH;
        end
      end
      vlt_pkg::S_FINISH: begin
        res_valid       = 1'b1;
        res_data.status = vlt_pkg::ST_OK;
        case (req.op)
          vlt_pkg::OP_CHECK: begin
            res_data.status = vote_st;
          end
          vlt_pkg::OP_RECORD: begin
            res_data.status = vote_st;
            if (vote_st == vlt_pkg::ST_OK) begin
              ram_we         = res_ready;
              last_vote_next = req.slot;
              if (total == FULL_CNT) begin
                ram_waddr   = oldest;
                root_next   = oldest_slot;
                oldest_next = wrap_inc(oldest);
              end else begin
                total_next = total + CNT_W'(1);
              end
            end
          end
          vlt_pkg::OP_SETCOUNT: begin
            if (found) begin
              ram_we    = res_ready;
              ram_waddr = f_addr;
              ram_wdata = {req.slot, req.count_value};
            end else begin
              res_data.status = vlt_pkg::ST_NOT_FOUND;
            end
          end
          vlt_pkg::OP_RESET: begin
            root_next      = req.slot;
            last_vote_next = req.slot;
            total_next     = '0;
            oldest_next    = '0;
          end
          vlt_pkg::OP_LOOKUP: begin
            if (found) begin
              res_data.lockout   = f_lk;
              res_data.threshold = 9'(cfg.base_threshold) + 9'(f_cnt);
            end else begin
              res_data.status    = vlt_pkg::ST_NOT_FOUND;
              res_data.threshold = 9'(cfg.base_threshold);
            end
          end
          default: begin
          end
        endcase
        if (res_ready) begin
          state_next = vlt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = vlt_pkg::S_IDLE;
      end
    endcase

    res_data.root_now      = root_next;
    res_data.last_vote_now = last_vote_next;
    res_data.height        = 6'(total_next);
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= FULL_CNT)
    else $error("tower height beyond depth");

  a_oldest_bound: assert property (@(posedge clk) disable iff (rst)
    oldest <= LAST_IDX)
    else $error("oldest index out of range");

  a_write_in_finish: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == vlt_pkg::S_FINISH) && !rd_v && !s1_v)
    else $error("entry write while a walk is in flight");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != vlt_pkg::S_IDLE))
    else $error("accepted item left no work");

  a_finish_returns: assert property (@(posedge clk) disable iff (rst)
    finish_fire |=> (state == vlt_pkg::S_IDLE) && !rd_v)
    else $error("sequencer did not return to idle after a result");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vote lockout tower core. A tracker mirrors the
// tower, root, last vote and both registers, and predicts one result per
// accepted operation; results are compared in order as they are accepted.
// Stimulus is a short directed run followed by random sequences, each
// starting from a fresh root, under several register settings, with random
// idling on both channels, a long output stall and a mid-run drain.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 32;
  localparam int IDLE_PCT       = 38;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;

  class lockout_tracker;
    logic [63:0]   slots [DEPTH];
    logic [7:0]    counts [DEPTH];
    int unsigned   oldest = 0;
    int unsigned   total = 0;
    logic [63:0]   root = '0;
    logic [63:0]   last_vote = '0;
    logic [63:0]   max_lockout = vlt_pkg::MAX_LOCKOUT_RESET;
    logic [7:0]    base_threshold = vlt_pkg::BASE_THRESHOLD_RESET;
    vlt_pkg::out_t awaited [$];
    int            errors = 0;

    function void set_register(logic [vlt_pkg::CFG_IDX_W-1:0] index, logic [63:0] value);
      if (index == vlt_pkg::CFG_MAX_LOCKOUT) begin
        max_lockout = value;
      end else if (index == vlt_pkg::CFG_BASE_THRESHOLD) begin
        base_threshold = value[7:0];
      end
    endfunction

    function logic [63:0] lockout_for(logic [7:0] count);
      logic [63:0] span;
      if (count >= 8'd64) return max_lockout;
      span = 64'd1 << count;
      return (span < max_lockout) ? span : max_lockout;
    endfunction

    function int find_slot(logic [63:0] slot);
      int unsigned i;
      int unsigned p;
      for (i = 0; i < total; i++) begin
        p = (oldest + i) % DEPTH;
        if (slots[p] == slot) return int'(p);
      end
      return -1;
    endfunction

    function logic [2:0] vote_status(logic [63:0] slot);
      int unsigned i;
      int unsigned p;
      logic [64:0] reach;
      if (slot < root) return vlt_pkg::ST_BELOW_ROOT;
      if (slot <= last_vote) return vlt_pkg::ST_NOT_AFTER;
      for (i = 0; i < total; i++) begin
        p = (oldest + i) % DEPTH;
        // window end saturates at the top of the slot range
        reach = {1'b0, slots[p]} + {1'b0, lockout_for(counts[p])};
        if (slot > slots[p] && (reach[64] || slot <= reach[63:0])) return vlt_pkg::ST_LOCKED;
      end
      return vlt_pkg::ST_OK;
    endfunction

    function void note_op(vlt_pkg::in_t op_in);
      vlt_pkg::out_t exp;
      int            hit;
      exp = '0;
      exp.status = vlt_pkg::ST_OK;
      case (op_in.op)
        vlt_pkg::OP_CHECK: begin
          exp.status = vote_status(op_in.slot);
        end
        vlt_pkg::OP_RECORD: begin
          exp.status = vote_status(op_in.slot);
          if (exp.status == vlt_pkg::ST_OK) begin
            if (total >= DEPTH) begin
              // full tower: oldest entry leaves and becomes the root
              root = slots[oldest];
              slots[oldest] = op_in.slot;
              counts[oldest] = '0;
              oldest = (oldest + 1) % DEPTH;
            end else begin
              slots[(oldest + total) % DEPTH] = op_in.slot;
              counts[(oldest + total) % DEPTH] = '0;
              total++;
            end
            last_vote = op_in.slot;
          end
        end
        vlt_pkg::OP_SETCOUNT: begin
          hit = find_slot(op_in.slot);
          if (hit < 0) begin
            exp.status = vlt_pkg::ST_NOT_FOUND;
          end else begin
            counts[hit] = op_in.count_value;
          end
        end
        vlt_pkg::OP_RESET: begin
          root = op_in.slot;
          last_vote = op_in.slot;
          total = 0;
          oldest = 0;
        end
        vlt_pkg::OP_LOOKUP: begin
          hit = find_slot(op_in.slot);
          if (hit < 0) begin
            exp.status = vlt_pkg::ST_NOT_FOUND;
            exp.threshold = {1'b0, base_threshold};
          end else begin
            exp.lockout = lockout_for(counts[hit]);
            exp.threshold = {1'b0, base_threshold} + {1'b0, counts[hit]};
          end
        end
        default: begin
        end
      endcase
      exp.root_now = root;
      exp.last_vote_now = last_vote;
      exp.height = 6'(total);
      awaited = {awaited, exp};
    endfunction

    function void check_result(vlt_pkg::out_t got);
      vlt_pkg::out_t exp;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing awaited: %p", $time, got);
        return;
      end
      exp = awaited.pop_front();
      if (got !== exp) begin
        errors++;
        $display("%0t: result mismatch\n  expected %p\n  actual   %p", $time, exp, got);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  vlt_pkg::in_t                  in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  vlt_pkg::out_t                 out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [vlt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]                   cfg_data = '0;

  bit             calm = 1'b0;
  bit             hold_off = 1'b0;
  bit             hold_done = 1'b0;
  int             idle_cycles = 0;
  lockout_tracker tower;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  vote_lockout_tower_core #(
    .TOWER_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tower.note_op(in_data);
      if (out_valid && out_ready) tower.check_result(out_data);
      if (cfg_valid && cfg_ready) tower.set_register(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // result side: random back-pressure, or a long hold when asked
  always @(negedge clk) begin
    if (hold_off && !hold_done) begin
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_done = 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_op(input logic [2:0] op, input logic [63:0] slot,
                         input logic [7:0] count_value);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 80)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{op: op, slot: slot, count_value: count_value};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tower.awaited.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input logic [63:0] max_lockout, input logic [7:0] base_threshold);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= vlt_pkg::CFG_MAX_LOCKOUT;
    cfg_data <= max_lockout;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    // upper bits of the threshold write are junk and must be dropped
    cfg_index <= vlt_pkg::CFG_BASE_THRESHOLD;
    cfg_data <= {$urandom, 24'($urandom), base_threshold};
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] slot_gap();
    int unsigned k;
    logic [63:0] r;
    k = $urandom_range(40);
    r = {$urandom, $urandom};
    return (r & ((64'd1 << k) - 64'd1)) + 64'd1;
  endfunction

  function automatic logic [63:0] live_slot();
    if (tower.total == 0) return tower.last_vote;
    return tower.slots[(tower.oldest + $urandom_range(tower.total - 1)) % DEPTH];
  endfunction

  task automatic random_op();
    int          pick;
    logic [7:0]  count;
    logic [63:0] probe;
    pick = $urandom_range(99);
    count = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(12));
    case ($urandom_range(3))
      0: probe = live_slot() + slot_gap();
      1: probe = tower.last_vote + slot_gap();
      2: probe = tower.root - slot_gap();
      default: probe = {$urandom, $urandom};
    endcase
    if (pick < 48) begin
      send_op(vlt_pkg::OP_RECORD, tower.last_vote + slot_gap(), count);
    end else if (pick < 62) begin
      send_op(vlt_pkg::OP_CHECK, probe, count);
    end else if (pick < 76) begin
      send_op(vlt_pkg::OP_SETCOUNT, (pick < 73) ? live_slot() : probe, count);
    end else if (pick < 90) begin
      send_op(vlt_pkg::OP_LOOKUP, (pick < 87) ? live_slot() : probe, count);
    end else if (pick < 91) begin
      send_op(vlt_pkg::OP_RESET, probe, count);
    end else if (pick < 93) begin
      send_op(OP_UNUSED_FIRST + 3'($urandom_range(2)), probe, count);
    end else begin
      send_op(3'($urandom), {$urandom, $urandom}, 8'($urandom));
    end
  endtask

  // each sequence starts from a fresh root so the tower can fill and evict
  task automatic random_run(input int n);
    int          sent;
    int          seq_len;
    logic [63:0] start;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(7))
        0: start = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(5000));
        1: start = {$urandom, $urandom};
        default: start = tower.last_vote + slot_gap();
      endcase
      send_op(vlt_pkg::OP_RESET, start, 8'($urandom));
      seq_len = $urandom_range(20, 150);
      for (int i = 0; i < seq_len && sent < n; i++) begin
        random_op();
        sent++;
      end
    end
  endtask

  initial begin
    tower = new;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_op(vlt_pkg::OP_CHECK, 64'd0, 8'd0);
    send_op(vlt_pkg::OP_RECORD, 64'd0, 8'd0);
    send_op(vlt_pkg::OP_LOOKUP, 64'd0, 8'hFF);
    send_op(vlt_pkg::OP_SETCOUNT, 64'd5, 8'd3);
    send_op(vlt_pkg::OP_RECORD, 64'd10, 8'd0);
    send_op(vlt_pkg::OP_CHECK, 64'd11, 8'd0);
    send_op(vlt_pkg::OP_RECORD, 64'd12, 8'd0);
    send_op(vlt_pkg::OP_SETCOUNT, 64'd12, 8'hFF);
    send_op(vlt_pkg::OP_LOOKUP, 64'd12, 8'd0);
    send_op(vlt_pkg::OP_CHECK, 64'd5, 8'd0);
    send_op(vlt_pkg::OP_RECORD, 64'd12 + vlt_pkg::MAX_LOCKOUT_RESET, 8'd0);
    send_op(vlt_pkg::OP_RECORD, 64'd13 + vlt_pkg::MAX_LOCKOUT_RESET, 8'd0);
    send_op(vlt_pkg::OP_LOOKUP, 64'd10, 8'd0);
    send_op(vlt_pkg::OP_RESET, 64'hFFFF_FFFF_FFFF_FFF0, 8'd0);
    send_op(vlt_pkg::OP_CHECK, 64'd5, 8'd0);
    send_op(vlt_pkg::OP_RECORD, 64'hFFFF_FFFF_FFFF_FFF8, 8'd0);
    send_op(vlt_pkg::OP_SETCOUNT, 64'hFFFF_FFFF_FFFF_FFF8, 8'd64);
    send_op(vlt_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
    send_op(vlt_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFF8, 8'd0);
    for (int i = 0; i < 3; i++) begin
      send_op(OP_UNUSED_FIRST + 3'(i), {$urandom, $urandom}, 8'($urandom));
    end
    send_op(vlt_pkg::OP_RESET, 64'd0, 8'd0);

    // smallest cap, largest base, no idling on either side
    write_config(64'd1, 8'hFF);
    calm = 1'b1;
    random_run(200);
    calm = 1'b0;

    // largest cap, zero base, long output hold while input keeps offering
    write_config(64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
    hold_off = 1'b1;
    random_run(250);

    // small cap, drain part way through
    write_config(64'($urandom_range(2, 5000)), 8'($urandom));
    random_run(125);
    settle();
    random_run(125);

    write_config(({$urandom, $urandom} >> $urandom_range(40)) | 64'd1, 8'($urandom));
    random_run(200);

    write_config(vlt_pkg::MAX_LOCKOUT_RESET, vlt_pkg::BASE_THRESHOLD_RESET);
    random_run(200);

    settle();
    if (tower.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
